/* rtl/core/fat_short_name_converter_defines.svh */
// Assertion macros used by the checker file of the short-name converter.
`ifndef FAT_SHORT_NAME_CONVERTER_DEFINES_SVH
`define FAT_SHORT_NAME_CONVERTER_DEFINES_SVH

// Same-cycle implication, gated off while reset is high.
`define FATSNC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, gated off while reset is high.
`define FATSNC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/fatsnc_pkg.sv */
// Types and constants of the FAT 8.3 short-name converter.
package fatsnc_pkg;

  localparam logic [7:0] SPACE_CH = 8'h20;
  localparam logic [7:0] SLASH_CH = 8'h2F;
  localparam logic [7:0] DOT_CH   = 8'h2E;
  localparam logic [7:0] NUL_CH   = 8'h00;

  localparam logic [3:0] SHORT_LEN = 4'd11;
  localparam logic [3:0] NAME_LEN  = 4'd8;
  localparam logic [1:0] EXT_LEN   = 2'd3;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_BAD    = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    PH_START,
    PH_NAME,
    PH_EXT
  } phase_t;

  // One unit of back-end work: bytes at positions pos_from..pos_to-1 all
  // carry fill, optionally followed by an end-status item.
  typedef struct packed {
    logic [3:0] pos_from;
    logic [3:0] pos_to;
    logic [7:0] fill;
    logic       with_status;
    logic       bad;
  } cmd_t;

  function automatic logic char_ok(input logic [7:0] c);
    char_ok = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

/* rtl/core/fatsnc_if.sv */
// Handshake channel interfaces for the character input and the short-name output.
interface fatsnc_in_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

interface fatsnc_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [3:0] out_position;
  logic [7:0] out_byte;
  logic       status;
  logic       last;

  modport source (output valid, output out_kind, output out_position, output out_byte,
                  output status, output last, input ready);
  modport sink (input valid, input out_kind, input out_position, input out_byte,
                input status, input last, output ready);
endinterface

/* rtl/core/fatsnc_queue.sv */
// Small command queue between the classifying front end and the emitting back end.
module fatsnc_queue #(
  parameter int Depth = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fatsnc_pkg::cmd_t wr_data,
  input  logic             pop,
  output fatsnc_pkg::cmd_t rd_data,
  output logic             empty,
  output logic             full
);
  import fatsnc_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t              mem [Depth];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;

  assign empty   = (count == '0);
  assign full    = (count == (AW+1)'(Depth));
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/fatsnc_front.sv */
// Front end: accepts characters, tracks name/extension state, queues emit commands.
module fatsnc_front (
  input  logic             clk,
  input  logic             rst,
  fatsnc_in_if.sink        chars,
  input  logic             queue_full,
  output logic             push,
  output fatsnc_pkg::cmd_t cmd
);
  import fatsnc_pkg::*;

  phase_t     phase, phase_next;
  logic [3:0] name_count, name_count_next;
  logic [1:0] ext_count, ext_count_next;
  logic       error_seen, error_seen_next;
  logic       accept;
  logic [7:0] c;
  logic       bad_end;

  assign chars.ready = !queue_full;
  assign accept      = chars.valid && !queue_full;
  assign c           = chars.in_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      name_count <= '0;
      ext_count  <= '0;
      error_seen <= 1'b0;
    end else begin
      phase      <= phase_next;
      name_count <= name_count_next;
      ext_count  <= ext_count_next;
      error_seen <= error_seen_next;
    end
  end

  always_comb begin
    phase_next      = phase;
    name_count_next = name_count;
    ext_count_next  = ext_count;
    error_seen_next = error_seen;
    push            = 1'b0;
    cmd             = '{pos_from: name_count, pos_to: name_count + 4'd1, fill: c,
                        with_status: 1'b0, bad: ST_OK};
    bad_end         = error_seen || (phase == PH_START) ||
                      (phase == PH_NAME && name_count == '0);

    if (accept) begin
      if (c == NUL_CH) begin
        // Terminator: pad the rest unless invalid, then report status.
        push            = 1'b1;
        cmd.fill        = SPACE_CH;
        cmd.pos_to      = SHORT_LEN;
        cmd.with_status = 1'b1;
        cmd.bad         = bad_end ? ST_BAD : ST_OK;
        if (bad_end) begin
          cmd.pos_from = SHORT_LEN;
        end else if (phase == PH_EXT) begin
          cmd.pos_from = {2'b10, ext_count};
        end else begin
          cmd.pos_from = name_count;
        end
        phase_next      = PH_START;
        name_count_next = '0;
        ext_count_next  = '0;
        error_seen_next = 1'b0;
      end else if (!error_seen) begin
        unique case (phase) inside
          PH_START, PH_NAME: begin
            if (phase == PH_START && c == SLASH_CH) begin
              phase_next = PH_NAME;
            end else if (c == DOT_CH) begin
              push           = (name_count < NAME_LEN);
              cmd.pos_to     = NAME_LEN;
              cmd.fill       = SPACE_CH;
              phase_next     = PH_EXT;
              ext_count_next = '0;
            end else if (name_count >= NAME_LEN || !char_ok(c)) begin
              error_seen_next = 1'b1;
              phase_next      = PH_NAME;
            end else begin
              push            = 1'b1;
              name_count_next = name_count + 4'd1;
              phase_next      = PH_NAME;
            end
          end
          // extension field; an unused phase code behaves the same way
          default: begin
            if (ext_count >= EXT_LEN || !char_ok(c)) begin
              error_seen_next = 1'b1;
            end else begin
              push           = 1'b1;
              cmd.pos_from   = {2'b10, ext_count};
              cmd.pos_to     = {2'b10, ext_count} + 4'd1;
              ext_count_next = ext_count + 2'd1;
            end
          end
        endcase
      end
    end
  end

endmodule

/* rtl/core/fatsnc_back.sv */
// Back end: walks queued commands; one item per cycle unless stalled.
module fatsnc_back (
  input  logic             clk,
  input  logic             rst,
  input  fatsnc_pkg::cmd_t head,
  input  logic             head_empty,
  output logic             pop,
  fatsnc_out_if.source     result
);
  import fatsnc_pkg::*;

  logic       started;
  logic [3:0] pos;
  logic [3:0] cur_pos;
  logic       load;
  logic       bytes_left;
  logic       final_byte;

  logic       ovalid;
  logic       okind;
  logic [3:0] opos;
  logic [7:0] obyte;
  logic       ostatus;
  logic       olast;

  assign cur_pos    = started ? pos : head.pos_from;
  assign bytes_left = (cur_pos < head.pos_to);
  assign final_byte = (cur_pos + 4'd1 == head.pos_to) && !head.with_status;
  assign load       = !head_empty && (!ovalid || result.ready);
  assign pop        = load && (!bytes_left || final_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      ovalid  <= 1'b0;
    end else begin
      if (load) begin
        started <= !pop;
        ovalid  <= 1'b1;
      end else if (result.ready) begin
        ovalid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pos <= cur_pos + 4'd1;
      if (bytes_left) begin
        okind   <= KIND_BYTE;
        opos    <= cur_pos;
        obyte   <= head.fill;
        ostatus <= ST_OK;
        olast   <= final_byte;
      end else begin
        okind   <= KIND_END;
        opos    <= '0;
        obyte   <= '0;
        ostatus <= head.bad;
        olast   <= 1'b1;
      end
    end
  end

  assign result.valid        = ovalid;
  assign result.out_kind     = okind;
  assign result.out_position = opos;
  assign result.out_byte     = obyte;
  assign result.status       = ostatus;
  assign result.last         = olast;

endmodule

/* rtl/core/fat_short_name_converter.sv */
// Top level of the FAT 8.3 short-name converter.
//
//   channel     dir   payload                                          per item
//   name_chars  in    in_char[7:0]                                     one name character
//   short_name  out   out_kind, out_position[3:0], out_byte[7:0],      one name byte or
//                     status, last                                     the end status
//
// A name character is taken every cycle while the command queue has room.
// Each valid name character yields one name byte; a dot yields up to 8 bytes
// of space padding and a terminator up to 11 items (padding plus status), from
// the back end emitting one item per cycle while the output is not stalled. The
// queue absorbs these runs, so the input stalls only when it fills. Output stalls
// hold the output register and back up through the queue. Synchronous reset clears
// name state and empties the queue and output register; no clearing pass is needed.
module fat_short_name_converter #(
  parameter int QueueDepth = fatsnc_pkg::QUEUE_DEPTH
) (
  input logic           clk,
  input logic           rst,
  fatsnc_in_if.sink     name_chars,
  fatsnc_out_if.source  short_name
);
  import fatsnc_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic queue_empty;
  logic queue_full;

  // Classify each character and keep the 8.3 field counters.
  fatsnc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .chars      (name_chars),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (front_cmd)
  );

  // Decouple classification from the padding runs of the back end.
  fatsnc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (front_cmd),
    .pop     (pop),
    .rd_data (head_cmd),
    .empty   (queue_empty),
    .full    (queue_full)
  );

  // Expand each command into byte and status items.
  fatsnc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_cmd),
    .head_empty (queue_empty),
    .pop        (pop),
    .result     (short_name)
  );

endmodule

/* rtl/core/fatsnc_checker.sv */
// Port-level checks for the short-name converter, bound to the top level.
`include "fat_short_name_converter_defines.svh"

module fatsnc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [3:0] out_position,
  input logic [7:0] out_byte,
  input logic       status,
  input logic       last
);
  import fatsnc_pkg::*;

  `FATSNC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_position) && $stable(out_byte) && $stable(status) && $stable(last), "stalled output item changed")
  `FATSNC_ASSERT_NOW(a_end_fields, clk, rst, out_valid && out_kind == KIND_END, out_position == 4'd0 && out_byte == 8'h00 && last, "end status item malformed")
  `FATSNC_ASSERT_NOW(a_byte_fields, clk, rst, out_valid && out_kind == KIND_BYTE, status == ST_OK && out_position <= 4'd10 && (out_byte == SPACE_CH || (out_byte >= 8'h41 && out_byte <= 8'h5A) || (out_byte >= 8'h30 && out_byte <= 8'h39)), "name byte item malformed")

endmodule

bind fat_short_name_converter fatsnc_checker u_fatsnc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (short_name.valid),
  .out_ready    (short_name.ready),
  .out_kind     (short_name.out_kind),
  .out_position (short_name.out_position),
  .out_byte     (short_name.out_byte),
  .status       (short_name.status),
  .last         (short_name.last)
);
